>>> hw/rtl/qec_pkg.sv
// ----------------------------------------------------------------------------
// qec_pkg
// shared types and constants of the quadrature counter
// ----------------------------------------------------------------------------
package qec_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned PPR_W    = 16;
  localparam int unsigned FILT_W   = 8;
  localparam int unsigned SPEED_W  = 32;
  // 60e6 * 256 / 4
  localparam logic [31:0] RPM_SCALE = 32'd3840000000;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_SPEED  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_PPR  = 2'd0,
    REG_FILT = 2'd1
  } reg_idx_t;

endpackage

>>> hw/rtl/qec_lane.sv
// ----------------------------------------------------------------------------
// qec_lane
// glitch filters and edge counter of one encoder channel
// ----------------------------------------------------------------------------
module qec_lane import qec_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   sample_en,
  input  logic                   clear_en,
  input  logic                   raw_a,
  input  logic                   raw_b,
  input  logic [FILT_W-1:0]      filter_cycles,
  output logic [COUNT_WIDTH-1:0] count
);

  logic              prev_a_r, prev_b_r, filt_a_r, filt_b_r;
  logic [FILT_W-1:0] stab_a_r, stab_b_r;
  logic [FILT_W-1:0] stab_a_nxt, stab_b_nxt;
  logic              filt_a_nxt, filt_b_nxt;
  logic [COUNT_WIDTH-1:0] count_r;

  always_comb begin
    if (raw_a == prev_a_r) begin
      stab_a_nxt = (stab_a_r == '1) ? stab_a_r : stab_a_r + 1'b1;
    end else begin
      stab_a_nxt = FILT_W'(1);
    end
    if (raw_b == prev_b_r) begin
      stab_b_nxt = (stab_b_r == '1) ? stab_b_r : stab_b_r + 1'b1;
    end else begin
      stab_b_nxt = FILT_W'(1);
    end
    filt_a_nxt = (stab_a_nxt >= filter_cycles) ? raw_a : filt_a_r;
    filt_b_nxt = (stab_b_nxt >= filter_cycles) ? raw_b : filt_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0; prev_b_r <= 1'b0;
      filt_a_r <= 1'b0; filt_b_r <= 1'b0;
      stab_a_r <= '0;   stab_b_r <= '0;
      count_r  <= '0;
    end else if (sample_en) begin
      prev_a_r <= raw_a; prev_b_r <= raw_b;
      stab_a_r <= stab_a_nxt; stab_b_r <= stab_b_nxt;
      filt_a_r <= filt_a_nxt; filt_b_r <= filt_b_nxt;
      if (filt_a_nxt != filt_a_r) begin
        if (filt_a_nxt ^ filt_b_nxt) count_r <= count_r + 1'b1;
        else count_r <= count_r - 1'b1;
      end
    end else if (clear_en) begin
      count_r <= '0;
    end
  end

  assign count = count_r;

endmodule

>>> hw/rtl/qec_div.sv
// ----------------------------------------------------------------------------
// qec_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qec_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        q_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> hw/rtl/quad_encoder_counter_rpm.sv
// ----------------------------------------------------------------------------
// quad_encoder_counter_rpm
// four-lane quadrature counter with per-channel speed measurement
// ----------------------------------------------------------------------------
// pin sample and clear act at the accepting edge, no result; count read or
// zero-ppr query: result registered on accept; zero-interval query: result
// loaded in the multiply stage; speed query: operand and multiply stages,
// divider start, 48-step divider, result stage (waits on stall); throughput:
// one sample, clear or read per cycle unless output stalls; a query holds the
// input; synchronous active-low reset clears counts, snapshots, filters and ppr
module quad_encoder_counter_rpm import qec_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0], channel[3:2], phase_a_levels[7:4], phase_b_levels[11:8],
  // time_us[59:12], zero pad [63:60]
  input  logic [63:0] in_tdata,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // position_count[15:0], speed_rpm_q8[47:16], speed_saturated[48], pad [55:49]
  output logic [55:0] out_tdata,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // magnitude at most 2^(COUNT_WIDTH-1) times the 32-bit scale
  localparam int unsigned NUM_W = COUNT_WIDTH + 32;
  localparam int unsigned DEN_W = PPR_W + TIME_W;
  // ppr times one 24-bit half of the time difference
  localparam int unsigned PART_W = PPR_W + 24;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [PPR_W-1:0]  ppr_r;
  logic [FILT_W-1:0] filt_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'({1'b0, cfg_paddr[2]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r  <= '0;
      filt_r <= FILT_W'(40);
    end else if (cfg_wr) begin
      if (cfg_idx == REG_FILT) filt_r <= cfg_pwdata[FILT_W-1:0];
      else ppr_r <= cfg_pwdata[PPR_W-1:0];
    end
  end

  // word address 0 is the pulse count per revolution, 1 is the filter length
  always_comb begin
    unique case (cfg_idx)
      REG_PPR:  cfg_prdata = {16'd0, ppr_r};
      default:  cfg_prdata = {24'd0, filt_r};
    endcase
  end

  // ---------------------------------------------------------------------------
  // input field decode
  // ---------------------------------------------------------------------------
  op_t               op;
  logic [1:0]        ch_in;
  logic [3:0]        a_lv, b_lv;
  logic [TIME_W-1:0] now;
  logic              ch_ok;
  logic [CH_W-1:0]   ch;
  logic              in_fire;

  assign op    = op_t'(in_tdata[1:0]);
  assign ch_in = in_tdata[3:2];
  assign a_lv  = in_tdata[7:4];
  assign b_lv  = in_tdata[11:8];
  assign now   = in_tdata[59:12];
  assign ch_ok = 32'(ch_in) < NUM_CHANNELS;
  assign ch    = CH_W'(ch_in);

  state_t state_r;
  logic   out_busy;       // result register holds an untaken result
  assign out_busy  = out_tvalid & ~out_tready;
  assign in_tready = (state_r == ST_IDLE) & ~out_busy;
  assign in_fire   = in_tvalid & in_tready;

  // ---------------------------------------------------------------------------
  // counting lanes, one per channel
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] cnt [NUM_CHANNELS];

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    qec_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .sample_en     (in_fire && op == OP_SAMPLE),
      .clear_en      (in_fire && op == OP_CLEAR && ch_ok && ch == CH_W'(g)),
      .raw_a         ((g < 4) ? a_lv[g % 4] : 1'b0),
      .raw_b         ((g < 4) ? b_lv[g % 4] : 1'b0),
      .filter_cycles (filt_r),
      .count         (cnt[g])
    );
  end

  // ---------------------------------------------------------------------------
  // snapshots, merging side: the addressed lane is selected here
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] snap_cnt_r  [NUM_CHANNELS];
  logic [TIME_W-1:0]      snap_time_r [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] delta;
  logic [TIME_W-1:0]      dt;
  logic                   speed_go;

  assign delta    = cnt[ch] - snap_cnt_r[ch];
  assign dt       = now - snap_time_r[ch];
  assign speed_go = in_fire && op == OP_SPEED && ch_ok && ppr_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        snap_cnt_r[i]  <= '0;
        snap_time_r[i] <= '0;
      end
    end else if (in_fire && ch_ok) begin
      if (op == OP_CLEAR) begin
        snap_cnt_r[ch]  <= '0;
        snap_time_r[ch] <= now;
      end else if (speed_go) begin
        snap_cnt_r[ch]  <= cnt[ch];
        snap_time_r[ch] <= now;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // speed path: register operands, one multiply stage, then the divider
  // ---------------------------------------------------------------------------
  logic                   neg_r;
  logic [COUNT_WIDTH-1:0] mag_r;
  logic [TIME_W-1:0]      dt_r;
  logic [NUM_W-1:0]       num_r;
  logic [PART_W-1:0]      den_lo_r, den_hi_r;
  logic [DEN_W-1:0]       den_sum;
  logic [COUNT_WIDTH-1:0] pos_r;
  logic                   div_start;
  logic                   div_go_r;
  logic                   div_done;
  logic [NUM_W-1:0]       quot;

  // a zero time difference divides by zero: the divider is skipped
  logic                   dt_zero_r;

  always_ff @(posedge clk) begin
    if (speed_go) begin
      neg_r     <= delta[COUNT_WIDTH-1];
      mag_r     <= delta[COUNT_WIDTH-1] ? (~delta + 1'b1) : delta;
      dt_r      <= dt;
      dt_zero_r <= dt == '0;
    end
    if (state_r == ST_MUL) begin
      num_r    <= NUM_W'(mag_r) * NUM_W'(RPM_SCALE);
      // ppr times the time difference as two 16 x 24 partial products
      den_lo_r <= PART_W'(ppr_r) * PART_W'(dt_r[23:0]);
      den_hi_r <= PART_W'(ppr_r) * PART_W'(dt_r[47:24]);
    end
  end

  assign den_sum = DEN_W'(den_lo_r) + (DEN_W'(den_hi_r) << 24);

  qec_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_sum),
    .done  (div_done),
    .quot  (quot)
  );

  // ---------------------------------------------------------------------------
  // control and result register
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] res_pos_r;
  logic [SPEED_W-1:0]     res_spd_r;
  logic                   res_sat_r;
  logic                   out_valid_r;
  logic [SPEED_W-1:0]     spd_nxt;
  logic                   sat_nxt;
  logic                   res_load;

  // divider starts the cycle after the multiply stage has filled its operands
  assign div_start = div_go_r;

  // result register takes a new result
  assign res_load = (in_fire && (op == OP_READ || op == OP_SPEED) && !speed_go) ||
                    (state_r == ST_MUL && dt_zero_r) ||
                    (state_r == ST_OUT && !out_busy);

  always_comb begin
    spd_nxt = '0;
    sat_nxt = 1'b0;
    if (neg_r) begin
      if (quot > NUM_W'(33'h080000000)) begin
        spd_nxt = 32'h80000000;
        sat_nxt = 1'b1;
      end else begin
        spd_nxt = SPEED_W'(~quot + 1'b1);
      end
    end else begin
      if (quot > NUM_W'(32'h7FFFFFFF)) begin
        spd_nxt = 32'h7FFFFFFF;
        sat_nxt = 1'b1;
      end else begin
        spd_nxt = quot[SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      div_go_r <= (state_r == ST_MUL) & ~dt_zero_r;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (op == OP_READ || op == OP_SPEED)) begin
            if (speed_go) begin
              pos_r   <= cnt[ch];
              state_r <= ST_MUL;
            end else begin
              res_pos_r <= ch_ok ? cnt[ch] : '0;
              res_spd_r <= '0;
              res_sat_r <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          if (dt_zero_r) begin
            res_pos_r <= pos_r;
            res_spd_r <= '0;
            res_sat_r <= 1'b0;
            state_r   <= ST_IDLE;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_busy) begin
            res_pos_r <= pos_r;
            res_spd_r <= spd_nxt;
            res_sat_r <= sat_nxt;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_sat_r, res_spd_r, 16'(res_pos_r)};

endmodule

>>> tb/tb_quad_encoder_counter_rpm.sv
// ----------------------------------------------------------------------------
// tb_quad_encoder_counter_rpm
// stream testbench: bursty pin samples, queries, clears and reads against a
// behavioural model of the counter, with register changes between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import qec_pkg::*;

typedef struct packed {
  logic        sat;
  logic [31:0] rpm;
  logic [15:0] pos;
} qec_result_t;

class encoder_scoreboard;
  logic [15:0] ppr;
  logic [7:0]  filt;
  logic [15:0] count [4];
  logic [15:0] snap_count [4];
  logic [47:0] snap_time [4];
  logic        lvl [8];
  logic [7:0]  stab [8];
  logic        prev [8];
  qec_result_t pending[$];
  int          mismatches;

  function void reset_state();
    ppr = 0;
    filt = 8'd40;
    for (int i = 0; i < 4; i++) begin
      count[i] = 0;
      snap_count[i] = 0;
      snap_time[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      lvl[i] = 0;
      stab[i] = 0;
      prev[i] = 0;
    end
    pending.delete();
    mismatches = 0;
  endfunction

  function void glitch_filter(int p, logic raw);
    if (raw == prev[p]) begin
      if (stab[p] != 8'hff) stab[p]++;
    end else begin
      stab[p] = 1;
    end
    prev[p] = raw;
    if (stab[p] >= filt) lvl[p] = raw;
  endfunction

  function logic [32:0] rpm_of(int c, logic [47:0] now);
    logic [15:0]  d;
    logic [47:0]  dt;
    logic [15:0]  mag;
    logic [127:0] q;
    logic [31:0]  rpm;
    logic         sat;
    if (ppr == 0) return 33'd0;
    d = count[c] - snap_count[c];
    dt = now - snap_time[c];
    snap_count[c] = count[c];
    snap_time[c] = now;
    if (dt == 0) return 33'd0;
    mag = d[15] ? (16'd0 - d) : d;
    q = (128'(mag) * 128'(RPM_SCALE)) / (128'(ppr) * 128'(dt));
    sat = 0;
    if (d[15]) begin
      if (q > 128'h8000_0000) begin
        q = 128'h8000_0000;
        sat = 1;
      end
      rpm = 32'd0 - q[31:0];
    end else begin
      if (q > 128'h7fff_ffff) begin
        q = 128'h7fff_ffff;
        sat = 1;
      end
      rpm = q[31:0];
    end
    return {sat, rpm};
  endfunction

  // note an accepted input transfer
  function void note_input(logic [63:0] t);
    op_t         op;
    int          c;
    logic [3:0]  a, b;
    logic [47:0] now;
    logic        old_a, up;
    logic [32:0] sr;
    op = op_t'(t[1:0]);
    c = t[3:2];
    a = t[7:4];
    b = t[11:8];
    now = t[59:12];
    case (op)
      OP_SAMPLE: begin
        for (int i = 0; i < 4; i++) begin
          old_a = lvl[i];
          glitch_filter(i, a[i]);
          glitch_filter(4 + i, b[i]);
          if (lvl[i] != old_a) begin
            up = lvl[i] ^ lvl[4 + i];
            count[i] = up ? count[i] + 16'd1 : count[i] - 16'd1;
          end
        end
      end
      OP_CLEAR: begin
        count[c] = 0;
        snap_count[c] = 0;
        snap_time[c] = now;
      end
      OP_SPEED: begin
        sr = rpm_of(c, now);
        pending.push_back('{sat: sr[32], rpm: sr[31:0], pos: count[c]});
      end
      default: pending.push_back('{sat: 1'b0, rpm: 32'd0, pos: count[c]});
    endcase
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_result(logic [55:0] t);
    qec_result_t want;
    qec_result_t got;
    got = t[48:0];
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", t);
      return;
    end
    want = pending.pop_front();
    if (got.pos !== want.pos || got.rpm !== want.rpm || got.sat !== want.sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected pos %h rpm %h sat %b, got pos %h rpm %h sat %b",
                 want.pos, want.rpm, want.sat, got.pos, got.rpm, got.sat);
    end
  endfunction
endclass

module tb_quad_encoder_counter_rpm;
  localparam int LIMIT = 2000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  // operation, channel, phase_a_levels, phase_b_levels, time_us, pad
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  // position_count, speed_rpm_q8, speed_saturated, pad
  logic [55:0] out_tdata;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  encoder_scoreboard sb;
  int          cycles = 0;
  int          stall_mode = 0;
  // per-encoder drive state for well-formed quadrature walks
  logic [1:0]  quad_phase [4];
  logic [47:0] clock_us = 0;
  logic [3:0]  cur_a = 0, cur_b = 0;

  quad_encoder_counter_rpm DUT (.*);

  always #10 clk = ~clk;

  // cycle limit guards against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sample both streams at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver stall pattern, switched per phase
  always @(negedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (cycles % 7 < 3);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= 3'(idx) << 2;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.filt = (idx == REG_FILT) ? val[7:0] : sb.filt;
    sb.ppr = (idx == REG_PPR) ? val[15:0] : sb.ppr;
  endtask

  task automatic reg_write_phase(logic [15:0] p, logic [7:0] f);
    in_tvalid <= 0;
    reg_write(REG_PPR, {16'd0, p});
    reg_write(REG_FILT, {24'd0, f});
  endtask

  // one transfer on the input stream; valid stays high across back-to-back items
  task automatic send(op_t op, logic [1:0] ch, logic [3:0] a, logic [3:0] b,
                      logic [47:0] t);
    in_tdata <= {4'd0, t, b, a, ch, op};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 4);
    if (n != 0) begin
      in_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    // a trailing sample or clear may still be in flight
    repeat (80) @(negedge clk);
  endtask

  // advance one encoder a quarter step along the gray sequence
  task automatic walk(int c, bit fwd);
    logic [1:0] g;
    quad_phase[c] = fwd ? quad_phase[c] + 2'd1 : quad_phase[c] - 2'd1;
    g = quad_phase[c] ^ (quad_phase[c] >> 1);
    cur_a[c] = g[0];
    cur_b[c] = g[1];
  endtask

  task automatic random_item();
    int   k;
    logic [47:0] t;
    k = $urandom_range(0, 99);
    clock_us = 48'(clock_us + 48'($urandom_range(0, 3000)));
    if (k < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        cur_a = 4'($urandom);
        cur_b = 4'($urandom);
      end else if ($urandom_range(0, 2) == 0) begin
        walk($urandom_range(0, 3), $urandom_range(0, 1));
      end
      send(OP_SAMPLE, 2'($urandom), cur_a, cur_b, 48'($urandom));
    end else if (k < 82) begin
      t = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) : clock_us;
      send(OP_SPEED, 2'($urandom), 4'($urandom), 4'($urandom), t);
    end else if (k < 86) begin
      send(OP_CLEAR, 2'($urandom), 4'($urandom), 4'($urandom), clock_us);
    end else begin
      send(OP_READ, 2'($urandom), 4'($urandom), 4'($urandom),
           48'({$urandom, $urandom}));
    end
  endtask

  initial begin
    int filts [4] = '{0, 1, 3, 255};
    int pprs [4] = '{1, 65535, 0, 500};
    sb = new();
    sb.reset_state();
    for (int i = 0; i < 4; i++) quad_phase[i] = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset-filter behaviour, zero ppr, extremes
    stall_mode = 0;
    send(OP_READ, 2'd0, 4'hf, 4'hf, 48'hffff_ffff_ffff);
    send(OP_SPEED, 2'd1, 4'h0, 4'h0, 48'd100);
    drain();
    reg_write_phase(16'd1, 8'd0);
    for (int i = 0; i < 4; i++) send(OP_SAMPLE, 2'd0, 4'hf, 4'h0, 48'd0);
    send(OP_SAMPLE, 2'd0, 4'h0, 4'hf, 48'd0);
    send(OP_SAMPLE, 2'd0, 4'hf, 4'hf, 48'd0);
    send(OP_SPEED, 2'd0, 4'h0, 4'h0, 48'd1);
    send(OP_SPEED, 2'd0, 4'h0, 4'h0, 48'd1);
    send(OP_SPEED, 2'd1, 4'h0, 4'h0, 48'hffff_ffff_ffff);
    send(OP_CLEAR, 2'd2, 4'h0, 4'h0, 48'hffff_ffff_ffff);
    send(OP_SAMPLE, 2'd0, 4'h0, 4'h0, 48'd0);
    send(OP_SAMPLE, 2'd0, 4'hf, 4'h0, 48'd0);
    send(OP_SPEED, 2'd2, 4'h0, 4'h0, 48'd0);
    send(OP_SPEED, 2'd3, 4'h0, 4'h0, 48'd1);
    send(OP_READ, 2'd3, 4'h0, 4'h0, 48'd0);
    drain();
    reg_write_phase(16'd65535, 8'd255);
    send(OP_SPEED, 2'd0, 4'h0, 4'h0, 48'd5);
    send(OP_READ, 2'd1, 4'h0, 4'h0, 48'd0);
    drain();

    // random phases across register settings and stall patterns
    for (int ph = 0; ph < 4; ph++) begin
      reg_write_phase(16'(pprs[ph]), 8'(filts[ph]));
      stall_mode = ph;
      for (int n = 0; n < 140; n++) begin
        random_item();
        if ($urandom_range(0, 5) == 0) gap();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
